// ===== rtl/aarf_pkg.sv =====
// Shared types and constants for the register file with ALU.
// No dependencies.
package aarf_pkg;

  localparam int XLEN    = 32;
  localparam int IDX_W   = 4;
  localparam int OP_W    = 2;
  localparam int FLAGS_W = 4;

  // Operation codes
  localparam logic [OP_W-1:0] OP_MOV = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD = 2'd1;
  localparam logic [OP_W-1:0] OP_SUB = 2'd2;
  localparam logic [OP_W-1:0] OP_CMP = 2'd3;

  // Bit positions inside NZCV
  localparam int FLAG_N_BIT = 3;
  localparam int FLAG_Z_BIT = 2;
  localparam int FLAG_C_BIT = 1;
  localparam int FLAG_V_BIT = 0;

  typedef logic [XLEN-1:0]    word_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [OP_W-1:0]    op_t;
  typedef logic [FLAGS_W-1:0] flags_t;

endpackage

// ===== rtl/aarf_cmd_if.sv =====
// Request channel carrying one instruction.
// Depends on aarf_pkg.
interface aarf_cmd_if import aarf_pkg::*; ();
  logic  valid;
  logic  ready;
  op_t   operation;
  idx_t  first_reg_index;
  idx_t  second_reg_index;
  word_t second_operand;
  logic  use_immediate;

  modport source (output valid, operation, first_reg_index, second_reg_index,
                  second_operand, use_immediate, input ready);
  modport sink   (input valid, operation, first_reg_index, second_reg_index,
                  second_operand, use_immediate, output ready);
endinterface

// ===== rtl/aarf_rsp_if.sv =====
// Result channel carrying one result per instruction.
// Depends on aarf_pkg.
interface aarf_rsp_if import aarf_pkg::*; ();
  logic   valid;
  logic   ready;
  word_t  result_value;
  flags_t flags_nzcv;
  logic   reg_written;

  modport source (output valid, result_value, flags_nzcv, reg_written, input ready);
  modport sink   (input valid, result_value, flags_nzcv, reg_written, output ready);
endinterface

// ===== rtl/aarf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module aarf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/arm_alu_register_file.sv =====
// Register file with ALU: one instruction in, one result out.
// Depends on aarf_pkg, aarf_cmd_if, aarf_rsp_if, aarf_ram.
//
// Takes one instruction per cycle unless the result side stalls, and returns
// one result per instruction: register read into stage 1, then execute into
// the output register. The register file sits in two copies of a RAM with
// registered read, written together, so compare can read two registers at
// once; the registered read is what sets the two-stage pipeline, and
// a write-back bypass covers back-to-back use of a register just written.
// Registers read as zero after reset through per-entry valid bits, so no
// clearing pass is needed. Indexes at or beyond NUM_REGS read zero and
// writes to them are dropped. Only compare updates NZCV.
module arm_alu_register_file import aarf_pkg::*; #(
  parameter int NUM_REGS = 16
) (
  input  logic       clk,
  input  logic       rst,
  aarf_cmd_if.sink   cmd,
  aarf_rsp_if.source rsp
);

  localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  typedef logic [AW-1:0] addr_t;

  // Pipeline control
  logic  s1_valid;
  logic  advance;
  logic  accept;

  // Stage 1 payload
  op_t   s1_op;
  addr_t s1_rd_addr;
  logic  s1_rd_ok;
  addr_t s1_a_addr;
  logic  s1_a_ok;
  addr_t s1_b_addr;
  logic  s1_b_ok;
  word_t s1_operand;
  logic  s1_imm;

  // Read side
  idx_t  a_idx;
  addr_t a_addr_in;
  logic  a_ok_in;
  addr_t b_addr_in;
  logic  b_ok_in;
  addr_t ram_a_raddr;
  addr_t ram_b_raddr;
  word_t ram_a_rdata;
  word_t ram_b_rdata;

  // Write-back bypass and valid bits
  logic  [NUM_REGS-1:0] reg_valid;
  logic  fwd_valid;
  addr_t fwd_addr;
  word_t fwd_data;

  // Execute
  word_t a_val;
  word_t b_val;
  word_t right;
  logic [XLEN:0] diff;
  word_t value;
  flags_t flags;
  flags_t flags_next;
  logic  wr_en;

  // Output register
  logic   out_valid;
  word_t  out_value;
  flags_t out_flags;
  logic   out_written;

  assign advance   = s1_valid && (!out_valid || rsp.ready);
  assign cmd.ready = !s1_valid || advance;
  assign accept    = cmd.valid && cmd.ready;

  // Port A: left register of compare, source of add/subtract.
  assign a_idx     = (cmd.operation == OP_CMP) ? cmd.first_reg_index : cmd.second_reg_index;
  assign a_addr_in = AW'(a_idx);
  assign a_ok_in   = 7'(a_idx) < 7'(NUM_REGS);
  // Port B: register operand of compare.
  assign b_addr_in = AW'(cmd.second_operand[IDX_W-1:0]);
  assign b_ok_in   = 7'(cmd.second_operand[IDX_W-1:0]) < 7'(NUM_REGS);

  // Hold the stalled item's address so the read data stays fresh.
  assign ram_a_raddr = accept ? a_addr_in : s1_a_addr;
  assign ram_b_raddr = accept ? b_addr_in : s1_b_addr;

  aarf_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_ram_a (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_rd_addr),
    .wdata (value),
    .raddr (ram_a_raddr),
    .rdata (ram_a_rdata)
  );

  aarf_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_ram_b (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_rd_addr),
    .wdata (value),
    .raddr (ram_b_raddr),
    .rdata (ram_b_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
    if (accept) begin
      s1_op      <= cmd.operation;
      s1_rd_addr <= AW'(cmd.first_reg_index);
      s1_rd_ok   <= 7'(cmd.first_reg_index) < 7'(NUM_REGS);
      s1_a_addr  <= a_addr_in;
      s1_a_ok    <= a_ok_in;
      s1_b_addr  <= b_addr_in;
      s1_b_ok    <= b_ok_in;
      s1_operand <= cmd.second_operand;
      s1_imm     <= cmd.use_immediate;
    end
  end

  // The bypass always mirrors the RAM at its address, so it may stay set.
  always_comb begin
    if (!s1_a_ok) begin
      a_val = '0;
    end else if (fwd_valid && fwd_addr == s1_a_addr) begin
      a_val = fwd_data;
    end else if (reg_valid[s1_a_addr]) begin
      a_val = ram_a_rdata;
    end else begin
      a_val = '0;
    end
    if (!s1_b_ok) begin
      b_val = '0;
    end else if (fwd_valid && fwd_addr == s1_b_addr) begin
      b_val = fwd_data;
    end else if (reg_valid[s1_b_addr]) begin
      b_val = ram_b_rdata;
    end else begin
      b_val = '0;
    end
  end

  always_comb begin
    right      = s1_imm ? s1_operand : b_val;
    diff       = {1'b0, a_val} - {1'b0, right};
    flags_next = flags;
    value      = '0;
    case (s1_op)
      OP_MOV: value = s1_operand;
      OP_ADD: value = a_val + s1_operand;
      OP_SUB: value = a_val - s1_operand;
      default: begin
        value                  = diff[XLEN-1:0];
        flags_next[FLAG_N_BIT] = diff[XLEN-1];
        flags_next[FLAG_Z_BIT] = (diff[XLEN-1:0] == '0);
        flags_next[FLAG_C_BIT] = !diff[XLEN];
        flags_next[FLAG_V_BIT] = (a_val[XLEN-1] ^ right[XLEN-1])
                               & (a_val[XLEN-1] ^ diff[XLEN-1]);
      end
    endcase
  end

  assign wr_en = advance && (s1_op != OP_CMP) && s1_rd_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_valid <= '0;
      fwd_valid <= 1'b0;
      flags     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        reg_valid[s1_rd_addr] <= 1'b1;
        fwd_valid             <= 1'b1;
      end
      if (advance) begin
        flags     <= flags_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (wr_en) begin
      fwd_addr <= s1_rd_addr;
      fwd_data <= value;
    end
    if (advance) begin
      out_value   <= value;
      out_flags   <= flags_next;
      out_written <= wr_en;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.result_value = out_value;
  assign rsp.flags_nzcv   = out_flags;
  assign rsp.reg_written  = out_written;

endmodule

// ===== rtl/aarf_checker.sv =====
// Port-level checks for the register file with ALU, bound to the top level.
// Depends on aarf_pkg and arm_alu_register_file.
module aarf_checker import aarf_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   rsp_valid,
  input logic   rsp_ready,
  input word_t  rsp_value,
  input flags_t rsp_flags,
  input logic   rsp_written
);

  // Flags of the last delivered result.
  flags_t prev_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_flags <= '0;
    end else if (rsp_valid && rsp_ready) begin
      prev_flags <= rsp_flags;
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_flags))
    else $error("stalled result changed");

  a_write_keeps_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_written |-> rsp_flags == prev_flags)
    else $error("register write changed flags");

  a_flags_match_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_written && rsp_flags != prev_flags |->
      rsp_flags[FLAG_Z_BIT] == (rsp_value == '0) &&
      rsp_flags[FLAG_N_BIT] == rsp_value[XLEN-1])
    else $error("new flags disagree with compare result");

endmodule

bind arm_alu_register_file aarf_checker u_aarf_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_value   (rsp.result_value),
  .rsp_flags   (rsp.flags_nzcv),
  .rsp_written (rsp.reg_written)
);
